/* hdl/sktl_pkg.sv */
package sktl_pkg;

    localparam int KEY_W   = 64;
    localparam int PORT_VW = 32;
    localparam int IDX_W   = 8;
    localparam int IOUT_W  = 10;
    localparam int CNT_W   = 9;

    typedef enum logic [3:0] {
        OP_PUT       = 4'd0,
        OP_APPEND    = 4'd1,
        OP_GET       = 4'd2,
        OP_DELETE    = 4'd3,
        OP_DELETE_AT = 4'd4,
        OP_KEY_AT    = 4'd5,
        OP_VALUE_AT  = 4'd6,
        OP_SET_AT    = 4'd7,
        OP_IDX_KEY   = 4'd8,
        OP_IDX_VAL   = 4'd9,
        OP_CLEAR     = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CMP_RD,
        S_CMP_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SRCH_END,
        S_PUT_CHK,
        S_APP_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_IDX_CHK,
        S_VAL_RD,
        S_VAL_CHK,
        S_DONE
    } t_state;

endpackage

/* hdl/sktl_cmp.sv */
module sktl_cmp
    import sktl_pkg::*;
(
    input  logic signed [KEY_W-1:0] i_a,
    input  logic signed [KEY_W-1:0] i_b,
    output logic                    o_lt,
    output logic                    o_eq
);

    assign o_lt = i_a < i_b;
    assign o_eq = i_a == i_b;

endmodule

/* hdl/sktl_store.sv */
module sktl_store
    import sktl_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 8
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [KEY_W-1:0]      i_wr_key,
    input  logic [VALUE_BITS-1:0] i_wr_val,
    input  logic                  i_wr_mark,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [KEY_W-1:0]      o_rd_key,
    output logic [VALUE_BITS-1:0] o_rd_val,
    output logic                  o_rd_mark
);

    logic [KEY_W-1:0]      r_key_mem  [CAPACITY];
    logic [VALUE_BITS-1:0] r_val_mem  [CAPACITY];
    logic                  r_mark_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr]  <= i_wr_key;
            r_val_mem[i_wr_addr]  <= i_wr_val;
            r_mark_mem[i_wr_addr] <= i_wr_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_key  <= r_key_mem[i_rd_addr];
            o_rd_val  <= r_val_mem[i_rd_addr];
            o_rd_mark <= r_mark_mem[i_rd_addr];
        end
    end

endmodule

/* hdl/sorted_key_table_lazy_delete_top.sv */
// Sorted map of signed 64-bit keys to value handles, one entry memory with one
// write and one registered read port. One transfer in, one result out; the
// block takes no new item until the current one has finished. The work per
// item: a binary search (put, get, delete, index of key), plus a shift of each
// entry at or after the insert point on an insert, plus a pass over all
// entries when a lazy compaction runs, a scan of the entries for index of
// value, and one direct read for indexed accesses (none for clear). All of it
// is paced by the single read port: every probe, shift and compaction step is
// one read followed by one decision or write.
module sorted_key_table_lazy_delete_top
    import sktl_pkg::*;
#(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [3:0]               i_operation,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic [PORT_VW-1:0]       i_value,
    input  logic [IDX_W-1:0]         i_index,
    input  logic [PORT_VW-1:0]       i_default_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [PORT_VW-1:0]       o_value_out,
    output logic signed [KEY_W-1:0]  o_key_out,
    output logic signed [IOUT_W-1:0] o_index_out,
    output logic [CNT_W-1:0]         o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [PORT_VW-1:0]    r_dflt, n_dflt;
    logic [CW-1:0]         r_used, n_used;
    logic                  r_garbage, n_garbage;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_mid, n_mid;
    logic                  r_hit, n_hit;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_ci, n_ci;
    logic [CW-1:0]         r_co, n_co;
    t_status               r_res_status, n_res_status;
    logic [PORT_VW-1:0]    r_res_vout, n_res_vout;
    logic [KEY_W-1:0]      r_res_kout, n_res_kout;
    logic [IOUT_W-1:0]     r_res_iout, n_res_iout;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_o_status;
    logic [PORT_VW-1:0]    r_o_vout;
    logic [KEY_W-1:0]      r_o_kout;
    logic [IOUT_W-1:0]     r_o_iout;
    logic [CNT_W-1:0]      r_o_cnt;

    logic                  w_wr_en, w_wr_mark, w_rd_en;
    logic [AW-1:0]         w_wr_addr, w_rd_addr;
    logic [KEY_W-1:0]      w_wr_key, w_rd_key;
    logic [VALUE_BITS-1:0] w_wr_val, w_rd_val;
    logic                  w_rd_mark;
    logic [KEY_W-1:0]      w_cmp_a, w_cmp_b;
    logic                  w_lt, w_eq;
    logic                  w_full, w_in_xfer, w_load_out;
    logic [31:0]           w_pos32, w_ci32, w_used32;
    logic [CW-1:0]         w_mid;

    sktl_store #(
        .CAPACITY  (CAPACITY),
        .VALUE_BITS(VALUE_BITS),
        .AW        (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_key (w_wr_key),
        .i_wr_val (w_wr_val),
        .i_wr_mark(w_wr_mark),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_key (w_rd_key),
        .o_rd_val (w_rd_val),
        .o_rd_mark(w_rd_mark)
    );

    // shared compare: stored key against item key, or stored value against item value
    assign w_cmp_a = (r_state == S_VAL_CHK) ? KEY_W'(w_rd_val) : w_rd_key;
    assign w_cmp_b = (r_state == S_VAL_CHK) ? KEY_W'(r_val) : r_key;

    sktl_cmp u_cmp (
        .i_a (w_cmp_a),
        .i_b (w_cmp_b),
        .o_lt(w_lt),
        .o_eq(w_eq)
    );

    assign w_full    = r_used >= CW'(CAPACITY);
    assign w_in_xfer = i_in_valid && o_in_ready;
    assign w_pos32   = 32'(r_pos);
    assign w_ci32    = 32'(r_ci);
    assign w_used32  = 32'(r_used);
    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_dflt       = r_dflt;
        n_used       = r_used;
        n_garbage    = r_garbage;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_ci         = r_ci;
        n_co         = r_co;
        n_res_status = r_res_status;
        n_res_vout   = r_res_vout;
        n_res_kout   = r_res_kout;
        n_res_iout   = r_res_iout;
        n_out_valid  = r_out_valid;
        w_wr_en      = 1'b0;
        w_wr_addr    = AW'(r_pos);
        w_wr_key     = r_key;
        w_wr_val     = r_val;
        w_wr_mark    = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = AW'(r_pos);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_op         = t_op'(i_operation);
                    n_key        = i_key;
                    n_val        = VALUE_BITS'(i_value);
                    n_idx        = i_index;
                    n_dflt       = i_default_value;
                    n_res_status = ST_OK;
                    n_res_vout   = '0;
                    n_res_kout   = '0;
                    n_res_iout   = '0;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (r_garbage && (r_op inside {[OP_KEY_AT:OP_IDX_VAL]})) begin
                    n_ci    = '0;
                    n_co    = '0;
                    n_state = S_CMP_RD;
                end else begin
                    case (r_op)
                        OP_PUT, OP_GET, OP_DELETE, OP_IDX_KEY: begin
                            n_lo    = '0;
                            n_hi    = r_used;
                            n_state = S_SRCH_RD;
                        end
                        OP_APPEND: begin
                            w_rd_en   = r_used != '0;
                            w_rd_addr = AW'(r_used - 1'b1);
                            n_state   = S_APP_CHK;
                        end
                        OP_DELETE_AT, OP_KEY_AT, OP_VALUE_AT, OP_SET_AT: begin
                            if (XW'(r_idx) >= XW'(r_used)) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_DONE;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(r_idx);
                                n_state   = S_IDX_CHK;
                            end
                        end
                        OP_IDX_VAL: begin
                            n_ci         = '0;
                            n_res_status = ST_NOT_FOUND;
                            n_res_iout   = '1;
                            n_state      = S_VAL_RD;
                        end
                        OP_CLEAR: begin
                            n_used    = '0;
                            n_garbage = 1'b0;
                            n_state   = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CMP_RD: begin
                if (r_ci < r_used) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_ci);
                    n_state   = S_CMP_CHK;
                end else begin
                    n_used    = r_co;
                    n_garbage = 1'b0;
                    n_state   = S_DISPATCH;
                end
            end
            S_CMP_CHK: begin
                if (!w_rd_mark) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = AW'(r_co);
                    w_wr_key  = w_rd_key;
                    w_wr_val  = w_rd_val;
                    n_co      = r_co + 1'b1;
                end
                n_ci    = r_ci + 1'b1;
                n_state = S_CMP_RD;
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(w_mid);
                    n_mid     = w_mid;
                    n_state   = S_SRCH_CHK;
                end else begin
                    n_hit   = 1'b0;
                    n_pos   = r_lo;
                    n_state = S_SRCH_END;
                end
            end
            S_SRCH_CHK: begin
                if (w_eq) begin
                    n_hit   = 1'b1;
                    n_pos   = r_mid;
                    n_state = S_SRCH_END;
                end else begin
                    if (w_lt) begin
                        n_lo = r_mid + 1'b1;
                    end else begin
                        n_hi = r_mid;
                    end
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_END: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PUT, OP_APPEND: begin
                        if (r_hit) begin
                            w_wr_en = 1'b1;
                        end else begin
                            w_rd_en = r_pos < r_used;
                            n_state = S_PUT_CHK;
                        end
                    end
                    OP_GET: begin
                        if (r_hit && !w_rd_mark) begin
                            n_res_vout = PORT_VW'(w_rd_val);
                        end else begin
                            n_res_vout   = r_dflt;
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    OP_DELETE: begin
                        if (r_hit && !w_rd_mark) begin
                            w_wr_en   = 1'b1;
                            w_wr_key  = w_rd_key;
                            w_wr_val  = w_rd_val;
                            w_wr_mark = 1'b1;
                            n_garbage = 1'b1;
                        end else begin
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    OP_IDX_KEY: begin
                        if (r_hit) begin
                            n_res_iout = w_pos32[IOUT_W-1:0];
                        end else begin
                            n_res_iout   = ~w_pos32[IOUT_W-1:0];
                            n_res_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT_CHK: begin
                if (r_pos < r_used && w_rd_mark) begin
                    w_wr_en = 1'b1;
                    n_state = S_DONE;
                end else if (r_garbage && w_full) begin
                    n_ci    = '0;
                    n_co    = '0;
                    n_state = S_CMP_RD;
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_ci    = r_used;
                    n_state = S_SHIFT_RD;
                end
            end
            S_APP_CHK: begin
                if (r_used != '0 && !w_lt) begin
                    n_lo    = '0;
                    n_hi    = r_used;
                    n_state = S_SRCH_RD;
                end else if (r_garbage && w_full) begin
                    n_ci    = '0;
                    n_co    = '0;
                    n_state = S_CMP_RD;
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = AW'(r_used);
                    n_used    = r_used + 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_SHIFT_RD: begin
                if (r_ci > r_pos) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_ci - 1'b1);
                    n_state   = S_SHIFT_WR;
                end else begin
                    w_wr_en = 1'b1;
                    n_used  = r_used + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SHIFT_WR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(r_ci);
                w_wr_key  = w_rd_key;
                w_wr_val  = w_rd_val;
                w_wr_mark = w_rd_mark;
                n_ci      = r_ci - 1'b1;
                n_state   = S_SHIFT_RD;
            end
            S_IDX_CHK: begin
                w_wr_addr = AW'(r_idx);
                w_wr_key  = w_rd_key;
                case (r_op)
                    OP_DELETE_AT: begin
                        if (!w_rd_mark) begin
                            w_wr_en   = 1'b1;
                            w_wr_val  = w_rd_val;
                            w_wr_mark = 1'b1;
                            n_garbage = 1'b1;
                        end
                    end
                    OP_KEY_AT: n_res_kout = w_rd_key;
                    OP_VALUE_AT: n_res_vout = PORT_VW'(w_rd_val);
                    OP_SET_AT: w_wr_en = 1'b1;
                    default: n_res_status = ST_OK;
                endcase
                n_state = S_DONE;
            end
            S_VAL_RD: begin
                if (r_ci < r_used) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = AW'(r_ci);
                    n_state   = S_VAL_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_VAL_CHK: begin
                if (w_eq) begin
                    n_res_iout   = w_ci32[IOUT_W-1:0];
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_ci    = r_ci + 1'b1;
                    n_state = S_VAL_RD;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_garbage   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_garbage   <= n_garbage;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_dflt       <= n_dflt;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_ci         <= n_ci;
        r_co         <= n_co;
        r_res_status <= n_res_status;
        r_res_vout   <= n_res_vout;
        r_res_kout   <= n_res_kout;
        r_res_iout   <= n_res_iout;
        if (w_load_out) begin
            r_o_status <= r_res_status;
            r_o_vout   <= r_res_vout;
            r_o_kout   <= r_res_kout;
            r_o_iout   <= r_res_iout;
            r_o_cnt    <= w_used32[CNT_W-1:0];
        end
    end

    assign o_in_ready    = r_state == S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_value_out   = r_o_vout;
    assign o_key_out     = r_o_kout;
    assign o_index_out   = r_o_iout;
    assign o_entry_count = r_o_cnt;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_garbage_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_garbage |-> (r_used != '0))
        else $error("garbage flag set on empty table");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !w_wr_en)
        else $error("memory write outside an operation");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_CHK) |-> (r_lo <= r_mid && r_mid < r_hi && r_hi <= r_used))
        else $error("binary search probe outside window");

endmodule
